FILE: rtl/core/led_pkg.sv
// Shared types and constants for the line editor with echo.
// Holds the sequencer state type, key codes, result kinds and register indexes.
// No dependencies.
package led_pkg;

    // Key codes with fixed meaning
    localparam logic [7:0] KEY_NEWLINE   = 8'd10;
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_TAB       = 8'd9;
    localparam logic [7:0] KEY_SPACE     = 8'd32;

    // Result kinds
    localparam logic [1:0] KIND_ECHO     = 2'd0;
    localparam logic [1:0] KIND_LINE_CHR = 2'd1;
    localparam logic [1:0] KIND_LINE_END = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_LINE_CAPACITY = 3'd0;
    localparam logic [2:0] REG_TAB_WIDTH     = 3'd1;
    localparam logic [2:0] REG_PAGE_UP       = 3'd2;
    localparam logic [2:0] REG_PAGE_DOWN     = 3'd3;
    localparam logic [2:0] REG_CLEAR_SCREEN  = 3'd4;

    localparam int CAP_W     = 6;
    localparam int TAB_W     = 4;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAB,
        ST_DRAIN,
        ST_LINE_END
    } t_state;

endpackage

FILE: rtl/core/line_editor_with_echo_top.sv
// Line editor with echo: top level, line store memory and result sequencer.
// Depends on led_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_key_code) takes one key byte per
//   transaction. Output channel (o_out_valid / i_out_stall / o_kind, o_out_char,
//   o_line_length, o_last) delivers result transactions in order; o_last marks
//   the final result caused by a key. Keys that cause no result produce nothing.
//   A plain write port (i_cfg_we, i_cfg_idx, i_cfg_data) sets line capacity,
//   tab width and the three echo-only key codes; write it only while idle.
// Throughput:
//   One result per cycle when the receiver does not stall. A tab gives its spaces
//   one after the other. A newline first starts the read of the line store, then
//   returns each stored character through the registered read port, and then
//   gives the line end. Because the store read is registered, the read start
//   gives no result.
// Reset:
//   Synchronous, active low. Clears the fill count, the sequencer and the output
//   valid, and loads the register reset values. The line store is not cleared;
//   only entries below the fill count are ever read.
// Stall:
//   A stalled result holds in the output register; the sequencer waits and the
//   input channel stalls until the result is taken.
module line_editor_with_echo_top #(
    parameter int LINE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_key_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_char,
    output logic [4:0] o_line_length,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import led_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);

    // Configuration registers
    logic [CAP_W-1:0] r_capacity;
    logic [TAB_W-1:0] r_tab_spaces;
    logic [7:0]       r_page_up;
    logic [7:0]       r_page_down;
    logic [7:0]       r_clear_screen;

    // Sequencer state
    t_state           r_state, n_state;
    logic [FW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_idx, n_idx;
    logic [TAB_W-1:0] r_tab_left, n_tab_left;

    // Line store
    logic [7:0]    r_mem [LINE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [7:0]    mem_wdata;

    // Output register
    logic             r_out_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_char;
    logic [LEN_W-1:0] r_len;
    logic             r_last;

    logic             slot_free;
    logic             in_acc;
    logic             emit;
    logic [1:0]       e_kind;
    logic [7:0]       e_char;
    logic             e_last;
    logic [LEN_W-1:0] e_len;

    logic [CAP_W:0]   cap_ext;
    logic [CAP_W:0]   cap_eff;
    logic [FW-1:0]    lim;
    logic [FW-1:0]    fill_inc;
    logic             room;
    logic             room_next;
    logic [TAB_W-1:0] tab_cnt;
    logic [TAB_W-1:0] tab_rem;
    logic             is_special;

    // Effective character limit: min(capacity, depth) - 1, floor zero
    always_comb begin
        cap_ext = {1'b0, r_capacity};
        cap_eff = (cap_ext > (CAP_W + 1)'(LINE_DEPTH)) ? (CAP_W + 1)'(LINE_DEPTH) : cap_ext;
        lim     = (cap_eff == '0) ? '0 : FW'(cap_eff - 1'b1);
    end

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && slot_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fill_inc   = r_fill + FW'(1);
    assign room       = r_fill < lim;
    assign room_next  = fill_inc < lim;
    assign is_special = (i_key_code == r_page_up) || (i_key_code == r_page_down)
                      || (i_key_code == r_clear_screen);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_tab_left = r_tab_left;
        emit       = 1'b0;
        e_kind     = KIND_ECHO;
        e_char     = i_key_code;
        e_len      = '0;
        e_last     = 1'b1;
        mem_we     = 1'b0;
        mem_wdata  = i_key_code;
        rd_addr    = '0;
        tab_cnt    = (r_state == ST_TAB) ? r_tab_left : r_tab_spaces;
        tab_rem    = tab_cnt - 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_key_code == KEY_NEWLINE) begin
                        if (r_fill == '0) begin
                            // empty line: line end right away
                            emit   = 1'b1;
                            e_kind = KIND_LINE_END;
                            e_char = KEY_NEWLINE;
                        end else begin
                            // start reading entry zero
                            n_idx   = '0;
                            n_state = ST_DRAIN;
                        end
                    end else if (is_special) begin
                        emit = 1'b1;
                    end else if (i_key_code == KEY_BACKSPACE) begin
                        if (r_fill != '0) begin
                            emit   = 1'b1;
                            n_fill = r_fill - FW'(1);
                        end
                    end else if (i_key_code == KEY_TAB) begin
                        if ((r_tab_spaces != '0) && room) begin
                            emit      = 1'b1;
                            e_char    = KEY_SPACE;
                            mem_we    = 1'b1;
                            mem_wdata = KEY_SPACE;
                            n_fill    = fill_inc;
                            e_last    = (tab_rem == '0) || !room_next;
                            n_tab_left = tab_rem;
                            if (!e_last) begin
                                n_state = ST_TAB;
                            end
                        end
                    end else if (room) begin
                        emit   = 1'b1;
                        mem_we = 1'b1;
                        n_fill = fill_inc;
                    end
                end
            end
            ST_TAB: begin
                // room is guaranteed on entry; fill does not move while waiting
                if (slot_free) begin
                    emit       = 1'b1;
                    e_char     = KEY_SPACE;
                    mem_we     = 1'b1;
                    mem_wdata  = KEY_SPACE;
                    n_fill     = fill_inc;
                    e_last     = (tab_rem == '0) || !room_next;
                    n_tab_left = tab_rem;
                    if (e_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DRAIN: begin
                rd_addr = r_idx;
                if (slot_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_LINE_CHR;
                    e_char  = r_rd_data;
                    e_last  = 1'b0;
                    rd_addr = AW'(r_idx + 1'b1);
                    n_idx   = AW'(r_idx + 1'b1);
                    if ((FW'(r_idx) + FW'(1)) == r_fill) begin
                        n_state = ST_LINE_END;
                    end
                end
            end
            ST_LINE_END: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_LINE_END;
                    e_char  = KEY_NEWLINE;
                    e_len   = LEN_W'(r_fill);
                    n_fill  = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // length on an immediate empty-line end is zero, as set by default
    end

    // Sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_tab_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_idx      <= n_idx;
            r_tab_left <= n_tab_left;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: load on emit, hold otherwise
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= e_kind;
            r_char <= e_char;
            r_len  <= e_len;
            r_last <= e_last;
        end
    end

    // Line store: one write port at the fill position, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill[AW-1:0]] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity     <= CAP_W'(32);
            r_tab_spaces   <= TAB_W'(4);
            r_page_up      <= 8'd128;
            r_page_down    <= 8'd129;
            r_clear_screen <= 8'd130;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE_CAPACITY: r_capacity     <= i_cfg_data[CAP_W-1:0];
                REG_TAB_WIDTH:     r_tab_spaces   <= i_cfg_data[TAB_W-1:0];
                REG_PAGE_UP:       r_page_up      <= i_cfg_data;
                REG_PAGE_DOWN:     r_page_down    <= i_cfg_data;
                REG_CLEAR_SCREEN:  r_clear_screen <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_char    = r_char;
    assign o_line_length = r_len;
    assign o_last        = r_last;

`ifndef SYNTH
    // fill never reaches the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FW'(LINE_DEPTH))
        else $error("fill count reached store depth");

    // readback index stays below the fill
    a_drain_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (FW'(r_idx) < r_fill))
        else $error("readback index beyond fill");

    // a line end result always closes its key
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_LINE_END)) |-> r_last)
        else $error("line end without last");

    // the fill clears right after a line end is produced from the store
    a_fill_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_LINE_END) && slot_free) |=> (r_fill == '0))
        else $error("fill not cleared after line end");

    // store is never written while it is read back
    a_no_write_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DRAIN) || (r_state == ST_LINE_END)) |-> !mem_we)
        else $error("store write during readback");
`endif

endmodule
